// ===== design/absr_pkg.sv =====
`default_nettype none
package absr_pkg;

	localparam logic       FIN_FLAG  = 1'b1;
	localparam logic [2:0] CMD_IDENT = 3'd7;
	localparam logic [2:0] CMD_VALUE = 3'd6;

	localparam logic [2:0] IDENT_LAST = 3'd6;
	localparam logic [2:0] VALUE_LAST = 3'd5;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [31:0] counter_value;
	} absr_in_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       is_byte;
		logic       addressed;
		logic       last_of_run;
	} absr_out_t;

	typedef enum logic [1:0] {
		JOB_NOTICE = 2'd0,
		JOB_IDENT  = 2'd1,
		JOB_VALUE  = 2'd2
	} absr_kind_t;

	typedef struct packed {
		absr_kind_t  kind;
		logic [3:0]  addr;
		logic [31:0] counter;
	} absr_job_t;

	// one result of a job, picked by its position in the reply
	function automatic absr_out_t job_result(absr_job_t job, logic [2:0] idx);
		absr_out_t r;
		r.addressed   = 1'b1;
		r.is_byte     = 1'b1;
		r.tx_byte     = 8'h00;
		r.last_of_run = 1'b0;
		case (job.kind)
			JOB_IDENT: begin
				r.last_of_run = (idx == IDENT_LAST);
				case (idx)
					3'd0:    r.tx_byte = {1'b0, CMD_IDENT, job.addr};
					3'd1:    r.tx_byte = 8'h54;
					3'd2:    r.tx_byte = 8'h38;
					3'd3:    r.tx_byte = 8'h35;
					3'd4:    r.tx_byte = 8'h4D;
					3'd5:    r.tx_byte = 8'h30;
					default: r.tx_byte = {FIN_FLAG, 7'h30};
				endcase
			end
			JOB_VALUE: begin
				r.last_of_run = (idx == VALUE_LAST);
				case (idx)
					3'd0:    r.tx_byte = {1'b0, CMD_VALUE, job.addr};
					3'd1:    r.tx_byte = {1'b0, job.counter[6:0]};
					3'd2:    r.tx_byte = {1'b0, job.counter[13:7]};
					3'd3:    r.tx_byte = {1'b0, job.counter[20:14]};
					3'd4:    r.tx_byte = {1'b0, job.counter[27:21]};
					default: r.tx_byte = {FIN_FLAG, 3'b000, job.counter[31:28]};
				endcase
			end
			default: begin
				r.is_byte     = 1'b0;
				r.last_of_run = 1'b1;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/absr_front.sv =====
`default_nettype none
module absr_front
	import absr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire absr_in_t  in_word,
	input  wire logic [3:0] node_address,
	output logic           job_push,
	output absr_job_t      job,
	input  wire logic      job_full
);

	logic skipping_q;
	logic skipping_d;
	logic accept;
	logic fin;
	logic match;

	assign full   = job_full;
	assign accept = push && !job_full;
	assign fin    = in_word.rx_byte[7];
	assign match  = (in_word.rx_byte[3:0] == node_address);

	always_comb begin
		skipping_d  = skipping_q;
		job_push    = 1'b0;
		job.kind    = JOB_NOTICE;
		job.addr    = node_address;
		job.counter = in_word.counter_value;
		if (skipping_q) begin
			if (fin) skipping_d = 1'b0;
		end else if (!match) begin
			if (!fin) skipping_d = 1'b1;
		end else begin
			job_push = 1'b1;
			if (in_word.rx_byte == {FIN_FLAG, CMD_IDENT, node_address}) begin
				job.kind = JOB_IDENT;
			end else if (in_word.rx_byte == {FIN_FLAG, CMD_VALUE, node_address}) begin
				job.kind = JOB_VALUE;
			end else begin
				// addressed but not understood: one notice, skip rest of message
				if (!fin) skipping_d = 1'b1;
			end
		end
		if (!accept) job_push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skipping_q <= 1'b0;
		end else if (accept) begin
			skipping_q <= skipping_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/absr_jobq.sv =====
`default_nettype none
module absr_jobq
	import absr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire absr_job_t wr_job,
	output logic           full,
	input  wire logic      rd_en,
	output absr_job_t      rd_job,
	output logic           empty
);

	absr_job_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/absr_back.sv =====
`default_nettype none
module absr_back
	import absr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire absr_job_t job,
	input  wire logic      job_empty,
	output logic           job_pop,
	output logic           empty,
	input  wire logic      pop,
	output absr_out_t      out_word
);

	absr_job_t  job_q;
	logic       busy_q;
	logic [2:0] idx_q;
	absr_out_t  out_q;
	logic       valid_q;
	absr_out_t  cur;
	logic       slot_free;
	logic       emit;

	assign cur       = job_result(job_q, idx_q);
	assign slot_free = !valid_q || pop;
	assign emit      = busy_q && slot_free;
	assign job_pop   = !busy_q && !job_empty;
	assign empty     = !valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
		if (emit) out_q <= cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 3'd0;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
				if (cur.last_of_run) busy_q <= 1'b0;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/addressed_bus_slave_responder.sv =====
`default_nettype none
// channel   direction  handshake        payload
// in        input      push / full      in_word  (absr_in_t)
// out       output     empty / pop      out_word (absr_out_t)
// config    input      cfg_we           cfg_data (node address)
//
// input words are classified combinationally and queued (two jobs deep)
// the sequencer gives one result word per cycle while the output is popped;
// a reply is identify 7, value 6 or notice 1 words, set by the job sequencer
// asynchronous reset clears the skip flag, job queue, sequencer and address
// full rises when the job queue holds two jobs; pop stalls only the back end
module addressed_bus_slave_responder
	import absr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire absr_in_t   in_word,
	output logic            empty,
	input  wire logic       pop,
	output absr_out_t       out_word,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_data
);

	logic [3:0] node_address_q;
	logic       job_push;
	absr_job_t  front_job;
	logic       job_full;
	logic       job_pop;
	absr_job_t  head_job;
	logic       job_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= 4'd0;
		end else if (cfg_we) begin
			node_address_q <= cfg_data;
		end
	end

	absr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_word      (in_word),
		.node_address (node_address_q),
		.job_push     (job_push),
		.job          (front_job),
		.job_full     (job_full)
	);

	absr_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (front_job),
		.full   (job_full),
		.rd_en  (job_pop),
		.rd_job (head_job),
		.empty  (job_empty)
	);

	absr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top
	import absr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_WAIT   = 16;
	localparam int PHASE_WORDS = 35;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	absr_in_t   in_word;
	logic       empty;
	logic       pop;
	absr_out_t  out_word;
	logic       cfg_we;
	logic [3:0] cfg_data;

	addressed_bus_slave_responder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.empty    (empty),
		.pop      (pop),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// model of the responder
	logic [3:0]  node_addr;
	logic        skip_msg;
	absr_out_t   reply_q[$];

	int n_errors;
	int n_sent;
	int n_live;
	int n_checked;
	int n_ident;
	int n_value;
	int n_notice;
	int n_cfg;
	int cycle_count;
	int burst_left;
	int stall_count;
	int pop_mode;
	logic [7:0] stall_pat;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: check every word taken, then pick the next pop
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (reply_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected word tx_byte=%02h is_byte=%0b addressed=%0b last=%0b",
					$time, out_word.tx_byte, out_word.is_byte, out_word.addressed,
					out_word.last_of_run);
			end else begin
				if (out_word !== reply_q[0]) begin
					n_errors++;
					$display("%0t: mismatch expected tx_byte=%02h is_byte=%0b addressed=%0b last=%0b",
						$time, reply_q[0].tx_byte, reply_q[0].is_byte,
						reply_q[0].addressed, reply_q[0].last_of_run);
					$display("%0t:          actual   tx_byte=%02h is_byte=%0b addressed=%0b last=%0b",
						$time, out_word.tx_byte, out_word.is_byte, out_word.addressed,
						out_word.last_of_run);
				end
				void'(reply_q.pop_front());
				n_checked++;
			end
		end
		stall_count++;
		if (stall_count % 50 == 0) begin
			pop_mode = $urandom_range(0, 3);
			stall_pat = 8'($urandom);
		end
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= stall_pat[stall_count[2:0]];
		endcase
	end

	task automatic predict_reply(input absr_in_t w, output int nres);
		logic        fin;
		logic [7:0]  rx;
		logic [31:0] cnt;
		logic [7:0]  bytes[7];
		absr_kind_t  kind;
		absr_out_t   r;
		int          n;
		rx   = w.rx_byte;
		cnt  = w.counter_value;
		fin  = rx[7];
		nres = 0;
		n    = 0;
		if (skip_msg) begin
			// final word of a skipped message ends the skip
			if (fin)
				skip_msg = 1'b0;
			nres = -1;
			return;
		end
		if (rx[3:0] != node_addr) begin
			if (!fin)
				skip_msg = 1'b1;
			return;
		end
		if (rx == {FIN_FLAG, CMD_IDENT, node_addr})
			kind = JOB_IDENT;
		else if (rx == {FIN_FLAG, CMD_VALUE, node_addr})
			kind = JOB_VALUE;
		else
			kind = JOB_NOTICE;
		case (kind)
			JOB_IDENT: begin
				bytes[0] = {1'b0, CMD_IDENT, node_addr};
				bytes[1] = "T";
				bytes[2] = "8";
				bytes[3] = "5";
				bytes[4] = "M";
				bytes[5] = "0";
				bytes[6] = {FIN_FLAG, 7'h30};
				n = 7;
				n_ident++;
			end
			JOB_VALUE: begin
				bytes[0] = {1'b0, CMD_VALUE, node_addr};
				bytes[1] = {1'b0, cnt[6:0]};
				bytes[2] = {1'b0, cnt[13:7]};
				bytes[3] = {1'b0, cnt[20:14]};
				bytes[4] = {1'b0, cnt[27:21]};
				bytes[5] = {FIN_FLAG, 3'b000, cnt[31:28]};
				n = 6;
				n_value++;
			end
			default: begin
				if (!fin)
					skip_msg = 1'b1;
				r.tx_byte     = 8'h00;
				r.is_byte     = 1'b0;
				r.addressed   = 1'b1;
				r.last_of_run = 1'b1;
				reply_q.push_back(r);
				n_notice++;
				nres = 1;
				return;
			end
		endcase
		for (int i = 0; i < n; i++) begin
			r.tx_byte     = bytes[i];
			r.is_byte     = 1'b1;
			r.addressed   = 1'b1;
			r.last_of_run = (i == n - 1);
			reply_q.push_back(r);
		end
		nres = n;
	endtask

	// called at a rising edge; returns at the edge that took the word, or later after a random idle gap
	task automatic send_word(input logic [7:0] rx, input logic [31:0] cnt);
		absr_in_t w;
		int       nres;
		w.rx_byte       = rx;
		w.counter_value = cnt;
		push    <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (full);
		predict_reply(w, nres);
		n_sent++;
		if (nres >= 0)
			n_live++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(0, 8);
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_results();
		push <= 1'b0;
		do @(posedge clk); while (reply_q.size() != 0);
	endtask

	task automatic wait_idle();
		wait_results();
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic set_node_address(input logic [3:0] a);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_data <= a;
		@(posedge clk);
		cfg_we    <= 1'b0;
		node_addr  = a;
		n_cfg++;
	endtask

	task automatic test_identify();
		// address after reset is zero
		send_word(8'hF0, $urandom);
		set_node_address(4'hF);
		send_word(8'hFF, 32'h0000_0000);
	endtask

	task automatic test_value();
		send_word({FIN_FLAG, CMD_VALUE, node_addr}, 32'h0000_0000);
		send_word({FIN_FLAG, CMD_VALUE, node_addr}, 32'hFFFF_FFFF);
		send_word({FIN_FLAG, CMD_VALUE, node_addr}, 32'h1234_5678);
	endtask

	task automatic test_notice();
		set_node_address(4'h5);
		send_word(8'h85, $urandom);
		send_word(8'hD5, $urandom);
		// identify without final flag: notice, then the message is skipped
		send_word(8'h75, $urandom);
		send_word(8'hF5, $urandom);
		// value without final flag, then a skipped word and the closing word
		send_word(8'h65, $urandom);
		send_word(8'h05, $urandom);
		send_word(8'h85, $urandom);
	endtask

	task automatic test_mismatch();
		set_node_address(4'hA);
		send_word(8'h73, $urandom);
		// addressed identify swallowed while skipping, it ends the skip
		send_word(8'hFA, $urandom);
		send_word(8'hFA, $urandom);
		send_word(8'h83, $urandom);
		send_word(8'hEA, 32'hDEAD_BEEF);
		send_word(8'h00, $urandom);
		send_word(8'hFF, $urandom);
	endtask

	task automatic send_message();
		int          kind;
		int          len;
		logic [3:0]  other;
		logic [2:0]  cmd;
		logic        fin;
		logic [31:0] cnt;
		kind  = $urandom_range(0, 9);
		other = node_addr ^ 4'($urandom_range(1, 15));
		len   = $urandom_range(0, 3);
		case (kind)
			0, 1, 2: send_word({FIN_FLAG, CMD_IDENT, node_addr}, $urandom);
			3, 4, 5: begin
				case ($urandom_range(0, 5))
					0:       cnt = 32'h0000_0000;
					1:       cnt = 32'hFFFF_FFFF;
					default: cnt = $urandom;
				endcase
				send_word({FIN_FLAG, CMD_VALUE, node_addr}, cnt);
			end
			6: begin
				// message for another node
				send_word({1'b0, 3'($urandom), other}, $urandom);
				repeat (len) send_word({1'b0, 7'($urandom)}, $urandom);
				send_word({1'b1, 7'($urandom)}, $urandom);
			end
			7: begin
				cmd = 3'($urandom);
				fin = 1'($urandom);
				send_word({fin, cmd, node_addr}, $urandom);
				if (!fin) begin
					repeat (len) send_word({1'b0, 7'($urandom)}, $urandom);
					send_word({1'b1, 7'($urandom)}, $urandom);
				end
			end
			8: send_word(8'($urandom), $urandom);
			default: send_word({1'b1, 3'($urandom), other}, $urandom);
		endcase
	endtask

	task automatic test_random();
		logic [3:0] addrs[6];
		int         start;
		addrs[0] = 4'h0;
		addrs[1] = 4'hF;
		addrs[2] = 4'($urandom);
		addrs[3] = 4'h6;
		addrs[4] = 4'h9;
		addrs[5] = 4'($urandom);
		for (int p = 0; p < 6; p++) begin
			set_node_address(addrs[p]);
			start = n_live;
			while (n_live - start < PHASE_WORDS) begin
				send_message();
				// now and then the sender holds off until the replies are all out
				if ($urandom_range(0, 39) == 0)
					wait_results();
			end
		end
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		in_word     = '0;
		cfg_we      = 1'b0;
		cfg_data    = 4'h0;
		node_addr   = 4'h0;
		skip_msg    = 1'b0;
		n_errors    = 0;
		n_sent      = 0;
		n_live      = 0;
		n_checked   = 0;
		n_ident     = 0;
		n_value     = 0;
		n_notice    = 0;
		n_cfg       = 0;
		cycle_count = 0;
		burst_left  = 0;
		stall_count = 0;
		pop_mode    = 0;
		stall_pat   = 8'hA5;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identify();
		test_value();
		test_notice();
		test_mismatch();
		test_random();
		wait_idle();

		if (reply_q.size() != 0) begin
			n_errors++;
			$display("%0t: %0d expected words never came", $time, reply_q.size());
		end
		$display("run: %0d words sent, %0d result words checked over %0d address settings",
			n_sent, n_checked, n_cfg);
		$display("replies: %0d identify, %0d value, %0d notice, %0d errors",
			n_ident, n_value, n_notice, n_errors);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
